[design/rrkc_pkg.sv]
// ----------------------------------------------------------------------------
// rrkc_pkg
// Shared types and constants for the lag-table keystream byte cipher.
// ----------------------------------------------------------------------------
package rrkc_pkg;

  // Lag table geometry.
  localparam int unsigned LAG_LEN = 17;
  localparam int unsigned IDX_W   = 5;
  localparam logic [IDX_W-1:0] LAG_TOP = 5'd16;
  localparam logic [IDX_W-1:0] START_A = 5'd0;
  localparam logic [IDX_W-1:0] START_B = 5'd10;

  // Seed expansion multiplier.
  localparam logic [31:0] SEED_MULT = 32'h53A9_B4FB;

  // Generator steps run after a reseed, and per byte.
  localparam logic [IDX_W-1:0] WARMUP_STEPS   = 5'd9;
  localparam logic [IDX_W-1:0] STEPS_PER_BYTE = 5'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;       // capture the accepted input word
    logic             seed_step;  // write one expanded seed word
    logic [IDX_W-1:0] seed_addr;  // table entry for that seed word
    logic             step;       // run one generator step
    logic             load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

[design/rrkc_ram.sv]
// ----------------------------------------------------------------------------
// rrkc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rrkc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/rrkc_dpath.sv]
// ----------------------------------------------------------------------------
// rrkc_dpath
// Datapath: lag table, seed expander, generator step and output register.
// ----------------------------------------------------------------------------
module rrkc_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  rrkc_pkg::cmd_t         cmd,
  output rrkc_pkg::status_t      status,
  input  logic                   first_byte,
  input  logic [31:0]            seed,
  input  logic [7:0]             data_in,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [7:0]             data_out
);

  logic [7:0]                     data_hold;
  logic [31:0]                    seed_word;
  logic [31:0]                    seed_word_next;
  logic [rrkc_pkg::IDX_W-1:0]     index_a;
  logic [rrkc_pkg::IDX_W-1:0]     index_b;
  logic [rrkc_pkg::IDX_W-1:0]     index_a_next;
  logic [rrkc_pkg::IDX_W-1:0]     index_b_next;
  logic [rrkc_pkg::IDX_W-1:0]     raddr_a;
  logic [rrkc_pkg::IDX_W-1:0]     raddr_b;
  logic [rrkc_pkg::LAG_LEN-1:0]   entry_valid;
  logic                           rvalid_a;
  logic                           rvalid_b;
  logic [31:0]                    rdata_a;
  logic [31:0]                    rdata_b;
  logic [31:0]                    word_a;
  logic [31:0]                    word_b;
  logic [31:0]                    gen_word;
  logic [7:0]                     key;
  logic                           we;
  logic [rrkc_pkg::IDX_W-1:0]     waddr;
  logic [31:0]                    wdata;

  // Indices count down and wrap from zero to the top entry.
  assign index_a_next = (index_a == '0) ? rrkc_pkg::LAG_TOP : index_a - 1'b1;
  assign index_b_next = (index_b == '0) ? rrkc_pkg::LAG_TOP : index_b - 1'b1;

  // While a step retires, the next step's operands are already being read.
  assign raddr_a = cmd.step ? index_a_next : index_a;
  assign raddr_b = cmd.step ? index_b_next : index_b;

  // Seed expansion: s = 1 - s * multiplier, low 32 bits.
  assign seed_word_next = 32'd1 - (seed_word * rrkc_pkg::SEED_MULT);

  // Entries never written since reset read as zero.
  assign word_a   = rvalid_a ? rdata_a : '0;
  assign word_b   = rvalid_b ? rdata_b : '0;
  assign gen_word = {word_a[22:0], word_a[31:23]} + {word_b[18:0], word_b[31:19]};

  // One write port shared by seeding and generator steps.
  assign we    = cmd.seed_step | cmd.step;
  assign waddr = cmd.seed_step ? cmd.seed_addr : index_a;
  assign wdata = cmd.seed_step ? seed_word_next : gen_word;

  rrkc_ram #(
    .WIDTH(32),
    .DEPTH(rrkc_pkg::LAG_LEN)
  ) u_lag_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // Per-entry valid bits and the valid flags that travel with the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rvalid_a    <= 1'b0;
      rvalid_b    <= 1'b0;
    end else begin
      if (we) begin
        entry_valid[waddr] <= 1'b1;
      end
      rvalid_a <= entry_valid[raddr_a];
      rvalid_b <= entry_valid[raddr_b];
    end
  end

  // Generator indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_a <= '0;
      index_b <= '0;
    end else if (cmd.load && first_byte) begin
      index_a <= rrkc_pkg::START_A;
      index_b <= rrkc_pkg::START_B;
    end else if (cmd.step) begin
      index_a <= index_a_next;
      index_b <= index_b_next;
    end
  end

  // Input word, seed chain and keystream byte.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_hold <= data_in;
      seed_word <= seed;
    end else if (cmd.seed_step) begin
      seed_word <= seed_word_next;
    end
    if (cmd.step) begin
      key <= gen_word[31:24];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      data_out <= data_hold ^ key;
    end
  end

  assign status.out_valid = out_valid;

`ifndef SYNTHESIS
  // The indices never leave the table.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    index_a <= rrkc_pkg::LAG_TOP && index_b <= rrkc_pkg::LAG_TOP)
    else $error("generator index out of range");

  // A result moved to the output register is presented next cycle.
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("output word lost");

  // A waiting output word stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out))
    else $error("output word changed while waiting");
`endif

endmodule

[design/rrkc_ctrl.sv]
// ----------------------------------------------------------------------------
// rrkc_ctrl
// Controller: sequences seeding, generator steps and the output handoff.
// ----------------------------------------------------------------------------
module rrkc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  first_byte,
  input  logic                  out_ready,
  input  rrkc_pkg::status_t     status,
  output rrkc_pkg::cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [rrkc_pkg::IDX_W-1:0] cnt;
  logic [rrkc_pkg::IDX_W-1:0] cnt_next;
  logic                       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next-state and command decode.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.seed_addr  = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (first_byte) begin
            state_next = ST_SEED;
            cnt_next   = '0;
          end else begin
            state_next = ST_READ;
            cnt_next   = rrkc_pkg::STEPS_PER_BYTE - 1'b1;
          end
        end
      end
      ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (cnt == rrkc_pkg::LAG_TOP) begin
          state_next = ST_READ;
          cnt_next   = rrkc_pkg::WARMUP_STEPS + rrkc_pkg::STEPS_PER_BYTE - 1'b1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_READ: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_DONE: begin
        if (!status.out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  // A word that carries the first-byte flag always starts a reseed.
  a_first_seeds: assert property (@(posedge clk) disable iff (rst)
    accept && first_byte |=> state == ST_SEED)
    else $error("first byte did not start reseed");

  // The last generator step hands over to the output stage.
  a_step_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP && cnt == '0 |=> state == ST_DONE)
    else $error("step sequence did not finish");

  // The output register is never overwritten while its word waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !status.out_valid || out_ready)
    else $error("output word overwritten");
`endif

endmodule

[design/ranrot_keystream_byte_cipher.sv]
// ----------------------------------------------------------------------------
// ranrot_keystream_byte_cipher
// XOR keystream byte cipher driven by a lag-table rotate-add generator.
// ----------------------------------------------------------------------------
//
//   channel  handshake           payload
//   input    in_valid/in_ready   first_byte, seed[31:0], data_in[7:0]
//   output   out_valid/out_ready data_out[7:0]
//
// A word without the first-byte flag reaches the output register through a table
// read, two generator steps and a handoff. The flag first adds seed expansion of
// all 17 table entries and 9 warm-up steps.
// The next word can be accepted from the cycle after the handoff, not before;
// a result held while out_ready is low stalls the next handoff.
// Reset clears the indices and the table valid bits, so the table reads as zero.
// ----------------------------------------------------------------------------
module ranrot_keystream_byte_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_byte,
  input  logic [31:0] seed,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_out
);

  rrkc_pkg::cmd_t    cmd;
  rrkc_pkg::status_t status;

  rrkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .first_byte(first_byte),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rrkc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .first_byte(first_byte),
    .seed      (seed),
    .data_in   (data_in),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .data_out  (data_out)
  );

endmodule
